// File: rtl/sha_pkg.sv
// shared constants, types and round functions for the sha-256 stream hasher
package sha_pkg;

	localparam int unsigned QDepth = 4;
	localparam int unsigned QAw = 2;

	typedef enum logic [0:0] {
		KIND_DATA = 1'b0,
		KIND_FINISH = 1'b1
	} kind_t;

	// item passed from the front part to the back part
	typedef struct packed {
		kind_t kind;
		logic [7:0] data_byte;
	} item_t;

	typedef enum logic [5:0] {
		ST_LOAD = 6'b000001,
		ST_PAD = 6'b000010,
		ST_ROUND = 6'b000100,
		ST_ADD = 6'b001000,
		ST_EMIT = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	localparam logic [31:0] K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] H0 [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

// File: rtl/sha256_stream_hasher_top.sv
// top level of the sha-256 stream hasher
// every 64th data byte starts compression of the block (64 rounds)
// byte loading pauses while the single shared round unit compresses a block
// finish: padding and compression of one or two blocks, then eight digest items
// a 4-entry queue parts the input stage from the hashing core
// arst_n clears all control state and loads the initial hash values
module sha256_stream_hasher_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic kind,
	input logic [7:0] data_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] digest_word,
	output logic [2:0] word_index,
	output logic last_word
);
	logic f_valid;
	logic f_ready;
	sha_pkg::item_t f_item;
	logic c_valid;
	logic c_ready;
	sha_pkg::item_t c_item;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .ready(in_ready),
		.kind(kind), .data_byte(data_byte),
		.q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
	);

	sha_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(f_valid), .in_ready(f_ready),
		.in_item(f_item), .out_valid(c_valid), .out_ready(c_ready), .out_item(c_item)
	);

	sha_core u_core (
		.clk(clk), .arst_n(arst_n), .q_valid(c_valid), .q_ready(c_ready),
		.q_item(c_item), .out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);
endmodule

// File: rtl/sha_queue.sv
// short item queue between the front part and the back part
module sha_queue (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input sha_pkg::item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output sha_pkg::item_t out_item
);
	sha_pkg::item_t mem_q [sha_pkg::QDepth];
	logic [sha_pkg::QAw-1:0] wr_q;
	logic [sha_pkg::QAw-1:0] rd_q;
	logic [sha_pkg::QAw:0] cnt_q;
	logic push;
	logic pop;

	assign in_ready = (cnt_q != 3'(sha_pkg::QDepth));
	assign out_valid = (cnt_q != '0);
	assign out_item = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end
endmodule

// File: rtl/sha_front.sv
// input stage: registers and classifies incoming items
module sha_front (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic ready,
	input logic kind,
	input logic [7:0] data_byte,
	output logic q_valid,
	input logic q_ready,
	output sha_pkg::item_t q_item
);
	logic full_q;
	sha_pkg::item_t item_q;

	assign ready = !full_q || q_ready;
	assign q_valid = full_q;
	assign q_item = item_q;

	always_ff @(posedge clk) begin
		if (valid && ready) begin
			item_q.kind <= sha_pkg::kind_t'(kind);
			// data byte is don't-care on finish
			item_q.data_byte <= (kind == sha_pkg::KIND_FINISH) ? 8'h00 : data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (ready) begin
			full_q <= valid;
		end
	end
endmodule

// File: rtl/sha_core.sv
// back part: block buffer, padding, 64-round compression and digest output
module sha_core (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input sha_pkg::item_t q_item,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] digest_word,
	output logic [2:0] word_index,
	output logic last_word
);
	sha_pkg::state_t state_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0] fill_q;
	logic [63:0] bits_q;
	logic [5:0] rnd_q;
	logic fin_q;
	logic second_q;
	logic [63:0] total_q;
	logic [2:0] idx_q;
	logic [31:0] wnew;
	logic [31:0] wcur;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] e;
	logic [31:0] a;
	logic [5:0] bi;

	assign q_ready = (state_q == sha_pkg::ST_LOAD);
	assign out_valid = (state_q == sha_pkg::ST_EMIT);
	assign digest_word = h_q[idx_q];
	assign word_index = idx_q;
	assign last_word = (idx_q == 3'd7);

	assign wcur = w_q[0];
	assign wnew = sha_pkg::ssig1(w_q[14]) + w_q[9] + sha_pkg::ssig0(w_q[1]) + w_q[0];
	assign e = v_q[4];
	assign a = v_q[0];
	assign t1 = v_q[7] + sha_pkg::bsig1(e) + ((e & v_q[5]) ^ (~e & v_q[6]))
		+ sha_pkg::K[rnd_q] + wcur;
	assign t2 = sha_pkg::bsig0(a) + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign bi = fill_q;

	// write one byte into the 16-word schedule window, big-endian
	function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] p,
		input logic [7:0] b);
		logic [31:0] r;
		r = w;
		r[8*(3-p) +: 8] = b;
		return r;
	endfunction

	always_ff @(posedge clk) begin
		unique case (state_q)
			sha_pkg::ST_LOAD: begin
				if (q_valid && q_item.kind == sha_pkg::KIND_DATA) begin
					w_q[bi[5:2]] <= put_byte(w_q[bi[5:2]], bi[1:0], q_item.data_byte);
					if (bi == 6'd63) begin
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					end
				end else if (q_valid) begin
					total_q <= bits_q + {55'd0, bi, 3'd0};
					w_q[bi[5:2]] <= put_byte(w_q[bi[5:2]], bi[1:0], 8'h80);
				end
			end
			sha_pkg::ST_PAD: begin
				// zero the bytes after the 0x80 marker; place the length when this block has room for it
				for (int j = 0; j < 16; j++) begin
					for (int b = 0; b < 4; b++) begin
						if (6'(4*j+b) > bi) begin
							w_q[j][8*(3-b) +: 8] <= 8'h00;
						end
					end
				end
				if (second_q || bi < 6'd56) begin
					w_q[14] <= total_q[63:32];
					w_q[15] <= total_q[31:0];
				end
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			end
			sha_pkg::ST_ROUND: begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= wnew;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			sha_pkg::ST_DONE: begin
				// clear byte 0 of the extra padding block
				w_q[0][31:24] <= 8'h00;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::ST_LOAD;
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::H0[i];
			fill_q <= '0;
			bits_q <= '0;
			rnd_q <= '0;
			fin_q <= 1'b0;
			second_q <= 1'b0;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				sha_pkg::ST_LOAD: begin
					if (q_valid && q_item.kind == sha_pkg::KIND_DATA) begin
						fill_q <= fill_q + 1'b1;
						if (fill_q == 6'd63) begin
							fin_q <= 1'b0;
							rnd_q <= '0;
							state_q <= sha_pkg::ST_ROUND;
						end
					end else if (q_valid) begin
						fin_q <= 1'b1;
						second_q <= 1'b0;
						state_q <= sha_pkg::ST_PAD;
					end
				end
				sha_pkg::ST_PAD: begin
					rnd_q <= '0;
					state_q <= sha_pkg::ST_ROUND;
				end
				sha_pkg::ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 6'd63) begin
						state_q <= sha_pkg::ST_ADD;
					end
				end
				sha_pkg::ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					if (!fin_q) begin
						bits_q <= bits_q + 64'd512;
						state_q <= sha_pkg::ST_LOAD;
					end else if (!second_q && fill_q >= 6'd56) begin
						// marker left no room for the length: one more block of zeros
						second_q <= 1'b1;
						fill_q <= '0;
						state_q <= sha_pkg::ST_DONE;
					end else begin
						idx_q <= '0;
						state_q <= sha_pkg::ST_EMIT;
					end
				end
				sha_pkg::ST_DONE: begin
					// fill_q is zero here; pad clears bytes above 0, byte 0 cleared in the datapath
					state_q <= sha_pkg::ST_PAD;
				end
				sha_pkg::ST_EMIT: begin
					if (out_ready) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::H0[i];
							fill_q <= '0;
							bits_q <= '0;
							fin_q <= 1'b0;
							second_q <= 1'b0;
							state_q <= sha_pkg::ST_LOAD;
						end
					end
				end
				default: state_q <= sha_pkg::ST_LOAD;
			endcase
		end
	end
endmodule

// File: rtl/sha_checker.sv
// port-level checks for the sha-256 stream hasher
module sha_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] digest_word,
	input logic [2:0] word_index,
	input logic last_word
);
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd7)))
		else $error("last_word mismatch");

	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_word) |=> (word_index == $past(word_index) + 3'd1))
		else $error("digest words out of order");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(digest_word)))
		else $error("stalled digest word changed");

	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (word_index == 3'd0))
		else $error("digest does not start at word 0");
endmodule

bind sha256_stream_hasher_top sha_checker u_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
);

// File: test/tb_sha256_stream_hasher_top.sv
// testbench for the sha-256 stream hasher: random byte streams checked against a built-in digest
class digest_board;
	logic [31:0] state_h [8];
	logic [7:0] buf_bytes [64];
	int unsigned fill;
	logic [63:0] done_bits;
	logic [31:0] exp_word [$];
	logic [2:0] exp_idx [$];
	logic exp_last [$];
	int errors;

	function new();
		errors = 0;
		clear();
	endfunction

	function void clear();
		for (int i = 0; i < 8; i++) state_h[i] = sha_pkg::H0[i];
		fill = 0;
		done_bits = '0;
	endfunction

	function logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function void compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {buf_bytes[4*i], buf_bytes[4*i+1], buf_bytes[4*i+2], buf_bytes[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		for (int i = 0; i < 8; i++) v[i] = state_h[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::K[i] + w[i];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) state_h[i] += v[i];
	endfunction

	function void note_item(input logic k, input logic [7:0] b);
		int unsigned p;
		logic [63:0] total;
		if (k == sha_pkg::KIND_DATA) begin
			buf_bytes[fill] = b;
			fill++;
			if (fill == 64) begin
				compress();
				done_bits += 64'd512;
				fill = 0;
			end
			return;
		end
		p = fill;
		total = done_bits + 64'(p) * 8;
		buf_bytes[p] = 8'h80;
		p++;
		// no room for the length: spill into an extra block
		if (p > 56) begin
			while (p < 64) begin
				buf_bytes[p] = 8'h00;
				p++;
			end
			compress();
			p = 0;
		end
		while (p < 56) begin
			buf_bytes[p] = 8'h00;
			p++;
		end
		for (int i = 0; i < 8; i++) buf_bytes[56+i] = total[63-8*i -: 8];
		compress();
		for (int i = 0; i < 8; i++) begin
			exp_word.push_back(state_h[i]);
			exp_idx.push_back(3'(i));
			exp_last.push_back(i == 7);
		end
		clear();
	endfunction

	function void check_word(input logic [31:0] w, input logic [2:0] idx, input logic lst);
		if (exp_word.size() == 0) begin
			$error("digest word %h with nothing expected", w);
			errors++;
			return;
		end
		if (w !== exp_word[0]) begin
			$error("digest_word expected %h actual %h", exp_word[0], w);
			errors++;
		end
		if (idx !== exp_idx[0]) begin
			$error("word_index expected %0d actual %0d", exp_idx[0], idx);
			errors++;
		end
		if (lst !== exp_last[0]) begin
			$error("last_word expected %0d actual %0d", exp_last[0], lst);
			errors++;
		end
		void'(exp_word.pop_front());
		void'(exp_idx.pop_front());
		void'(exp_last.pop_front());
	endfunction
endclass

module tb_sha256_stream_hasher_top;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0] word_index;
	logic last_word;

	digest_board board = new();
	bit calm = 1'b0;

	sha256_stream_hasher_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic send_item(input logic k, input logic [7:0] b);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 18);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		board.note_item(k, b);
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) send_item(sha_pkg::KIND_DATA, 8'($urandom));
		send_item(sha_pkg::KIND_FINISH, 8'($urandom));
	endtask

	// drop valid and wait until every expected digest word is out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.exp_word.size() != 0) @(posedge clk);
	endtask

	// result side: random stall bursts, checked at the accepting edge
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				stall = $urandom_range(1, 18);
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			if (out_valid && out_ready) board.check_word(digest_word, word_index, last_word);
		end
	end

	initial begin
		int sent;
		int len;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: empty message, single bytes at extremes, padding boundaries
		send_item(sha_pkg::KIND_FINISH, 8'hff);
		send_item(sha_pkg::KIND_DATA, 8'h00);
		send_item(sha_pkg::KIND_FINISH, 8'h00);
		send_item(sha_pkg::KIND_DATA, 8'hff);
		send_item(sha_pkg::KIND_FINISH, 8'h00);
		send_message(55);
		send_message(56);
		send_message(63);
		send_message(64);
		// hold off until all digests are out
		drain();
		sent = 0;
		while (sent < 200) begin
			if (sent > 150) calm = 1'b1;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 140) : $urandom_range(0, 20);
			send_message(len);
			sent += len + 1;
		end
		drain();
		repeat (200) @(posedge clk);
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
